[rtl/core/rioc_pkg.sv]
// Shared types and constants for the register interval occupancy table.
// Used by the channel interfaces, the bound memory, the work list and the top level.
`default_nettype none
package rioc_pkg;

	// Field widths of the query and result items
	localparam int unsigned OP_W    = 2;
	localparam int unsigned REG_W   = 8;
	localparam int unsigned FIELD_W = 16;
	localparam int unsigned RES_W   = 9;
	localparam int unsigned STAT_W  = 2;

	// Time values kept in the lists
	localparam int unsigned TIME_BITS = 16;

	// Defaults for the top-level parameters
	localparam int unsigned DEF_MAX_REGISTERS    = 256;
	localparam int unsigned DEF_MAX_BOUNDS       = 32;
	localparam int unsigned DEF_MAX_QUERY_RANGES = 16;

	typedef enum logic [OP_W-1:0] {
		OP_CHECK = 2'd0,
		OP_FIND  = 2'd1,
		OP_ALLOC = 2'd2,
		OP_STACK = 2'd3
	} op_t;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_CONFLICT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

	// One bound: start time of a span and whether the span is occupied
	typedef struct packed {
		logic [TIME_BITS-1:0] tm;
		logic                 occ;
	} bound_t;

	// Edit operations on the working copy of a list
	typedef enum logic [2:0] {
		LOP_NONE,
		LOP_LOAD,
		LOP_INS,
		LOP_DEL,
		LOP_SET
	} lane_op_t;

	typedef struct packed {
		lane_op_t op;
		bound_t   data;
	} lane_cmd_t;

endpackage
`default_nettype wire

[rtl/core/rioc_in_if.sv]
// Query channel: valid/ready handshake with one range per transfer.
// Depends on rioc_pkg for field widths.
`default_nettype none
interface rioc_in_if;
	logic                         valid;
	logic                         ready;
	logic [rioc_pkg::OP_W-1:0]    operation;
	logic [rioc_pkg::REG_W-1:0]   reg_number;
	logic [rioc_pkg::FIELD_W-1:0] range_lower;
	logic [rioc_pkg::FIELD_W-1:0] range_upper;
	logic                         last_range;

	modport source (output valid, operation, reg_number, range_lower, range_upper, last_range,
		input ready);
	modport sink (input valid, operation, reg_number, range_lower, range_upper, last_range,
		output ready);
endinterface
`default_nettype wire

[rtl/core/rioc_out_if.sv]
// Result channel: valid/ready handshake with one answer per transfer.
// Depends on rioc_pkg for field widths.
`default_nettype none
interface rioc_out_if;
	logic                        valid;
	logic                        ready;
	logic [rioc_pkg::RES_W-1:0]  result_reg;
	logic                        is_free;
	logic [rioc_pkg::STAT_W-1:0] status;

	modport source (output valid, result_reg, is_free, status, input ready);
	modport sink (input valid, result_reg, is_free, status, output ready);
endinterface
`default_nettype wire

[rtl/core/rioc_bound_mem.sv]
// Bound storage: per-register bound lists and per-register bound counts.
// Synchronous memories with registered read; depends on rioc_pkg.
`default_nettype none
module rioc_bound_mem #(
	parameter int unsigned MAX_REGISTERS = rioc_pkg::DEF_MAX_REGISTERS,
	parameter int unsigned MAX_BOUNDS    = rioc_pkg::DEF_MAX_BOUNDS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [$clog2(MAX_REGISTERS)-1:0]   reg_sel,
	input  wire logic [$clog2(MAX_BOUNDS)-1:0]      rd_idx,
	output rioc_pkg::bound_t                        rd_data,
	input  wire logic                               wr_en,
	input  wire logic [$clog2(MAX_BOUNDS)-1:0]      wr_idx,
	input  wire rioc_pkg::bound_t                   wr_data,
	output logic [$clog2(MAX_BOUNDS+1)-1:0]         cnt_rd_data,
	input  wire logic                               cnt_wr_en,
	input  wire logic [$clog2(MAX_BOUNDS+1)-1:0]    cnt_wr_data
);
	localparam int unsigned DEPTH   = MAX_REGISTERS * MAX_BOUNDS;
	localparam int unsigned AW      = $clog2(DEPTH);
	localparam int unsigned BCNT_W  = $clog2(MAX_BOUNDS + 1);

	rioc_pkg::bound_t          mem [DEPTH];
	logic [BCNT_W-1:0]         cnt_mem [MAX_REGISTERS];
	logic [MAX_REGISTERS-1:0]  vld_q;
	logic [AW-1:0]             base;
	logic [AW-1:0]             rd_addr;
	logic [AW-1:0]             wr_addr;

	// Row base of the selected register
	assign base    = AW'(reg_sel) * AW'(MAX_BOUNDS);
	assign rd_addr = base + AW'(rd_idx);
	assign wr_addr = base + AW'(wr_idx);

	// Bound list memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

	// Count memory; an entry never written reads as zero
	always_ff @(posedge clk) begin
		if (cnt_wr_en) begin
			cnt_mem[reg_sel] <= cnt_wr_data;
		end
		cnt_rd_data <= vld_q[reg_sel] ? cnt_mem[reg_sel] : '0;
	end

	// Mark counts that hold data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cnt_wr_en) begin
			vld_q[reg_sel] <= 1'b1;
		end
	end
endmodule
`default_nettype wire

[rtl/core/rioc_work_list.sv]
// Working copy of one bound list with in-place insert and delete lanes.
// Registered read port; depends on rioc_pkg.
`default_nettype none
module rioc_work_list #(
	parameter int unsigned MAX_BOUNDS = rioc_pkg::DEF_MAX_BOUNDS
) (
	input  wire logic                           clk,
	input  wire rioc_pkg::lane_cmd_t            cmd,
	input  wire logic [$clog2(MAX_BOUNDS)-1:0]  pos,
	input  wire logic [$clog2(MAX_BOUNDS)-1:0]  rd_idx,
	output rioc_pkg::bound_t                    rd_data
);
	localparam int unsigned BIDX_W = $clog2(MAX_BOUNDS);

	rioc_pkg::bound_t lanes [MAX_BOUNDS];

	// Each lane picks its next value from itself, a neighbor or the command data
	for (genvar i = 0; i < MAX_BOUNDS; i++) begin : g_lane
		always_ff @(posedge clk) begin
			case (cmd.op)
				rioc_pkg::LOP_LOAD: begin
					if (BIDX_W'(i) == pos) lanes[i] <= cmd.data;
				end
				rioc_pkg::LOP_SET: begin
					if (BIDX_W'(i) == pos) lanes[i].occ <= 1'b1;
				end
				rioc_pkg::LOP_INS: begin
					if (BIDX_W'(i) == pos) begin
						lanes[i] <= cmd.data;
					end else if (BIDX_W'(i) > pos) begin
						if (i > 0) lanes[i] <= lanes[(i > 0) ? i - 1 : 0];
					end
				end
				rioc_pkg::LOP_DEL: begin
					if (BIDX_W'(i) >= pos && i < MAX_BOUNDS - 1) begin
						lanes[i] <= lanes[(i < MAX_BOUNDS - 1) ? i + 1 : i];
					end
				end
				default: ;
			endcase
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rd_data <= lanes[rd_idx];
	end
endmodule
`default_nettype wire

[rtl/core/register_interval_occupancy_table.sv]
// Register interval occupancy table, top level with query sequencer; one query at a time.
// A range item that is not last is taken while the sequencer idles; the last one starts the answer.
// Each register tested has its count read and a verdict, with a scan of its bounds per range;
// allocate also edits the list per range, loads the stored bounds first and writes the new
// list back. The answer then needs a free output register.
// Reset clears counts, registers in use and pending ranges at once; there is no clearing pass.
`default_nettype none
module register_interval_occupancy_table #(
	parameter int unsigned MAX_REGISTERS    = rioc_pkg::DEF_MAX_REGISTERS,
	parameter int unsigned MAX_BOUNDS       = rioc_pkg::DEF_MAX_BOUNDS,
	parameter int unsigned MAX_QUERY_RANGES = rioc_pkg::DEF_MAX_QUERY_RANGES
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rioc_in_if.sink    query,
	rioc_out_if.source result
);
	localparam int unsigned TB      = rioc_pkg::TIME_BITS;
	localparam int unsigned RW      = rioc_pkg::RES_W;
	localparam int unsigned SEL_W   = $clog2(MAX_REGISTERS);
	localparam int unsigned BIDX_W  = $clog2(MAX_BOUNDS);
	localparam int unsigned BCNT_W  = $clog2(MAX_BOUNDS + 1);
	localparam int unsigned QIDX_W  = (MAX_QUERY_RANGES > 1) ? $clog2(MAX_QUERY_RANGES) : 1;
	localparam int unsigned QCNT_W  = $clog2(MAX_QUERY_RANGES + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_CNT_RD, S_CNT_EV, S_LD_RD, S_LD_WR, S_RNG, S_SC_RD, S_SC_EV,
		S_EVAL, S_ALB, S_TDONE, S_WB_RD, S_WB_WR, S_WB_CNT, S_FIN
	} state_t;

	typedef struct packed {
		logic [TB-1:0] lo;
		logic [TB-1:0] hi;
	} range_t;

	state_t                   st_q;
	rioc_pkg::op_t            op_q;
	logic                     alloc_q;
	logic [RW-1:0]            r_q;
	logic [RW-1:0]            in_use_q;
	logic [BCNT_W-1:0]        n_q;
	logic [BIDX_W-1:0]        idx_q;
	logic [BIDX_W-1:0]        j_q;
	logic [BIDX_W-1:0]        k_q;
	rioc_pkg::bound_t         cur_q;
	logic [TB-1:0]            nxt_q;
	logic                     nend_q;
	logic [QCNT_W-1:0]        q_q;
	logic [TB-1:0]            lo_q;
	logic [TB-1:0]            hi_q;
	range_t                   st_rng_q;
	logic                     tfree_q;
	logic [RW-1:0]            res_q;
	logic                     free_q;
	logic [rioc_pkg::STAT_W-1:0] stat_q;
	logic                     out_valid_q;
	logic [RW-1:0]            out_res_q;
	logic                     out_free_q;
	logic [rioc_pkg::STAT_W-1:0] out_stat_q;
	logic [QCNT_W-1:0]        pend_cnt_q;
	range_t                   pend_q [MAX_QUERY_RANGES];

	logic                     in_xfer;
	range_t                   in_rng;
	logic                     in_keep;
	rioc_pkg::bound_t         mem_rd;
	rioc_pkg::bound_t         lst_rd;
	rioc_pkg::bound_t         scan_e;
	logic [BCNT_W-1:0]        cnt_rd;
	logic                     mem_wr_en;
	logic                     cnt_wr_en;
	rioc_pkg::lane_cmd_t      lcmd;
	logic [BIDX_W-1:0]        lpos;
	logic [QCNT_W-1:0]        qn;
	logic                     last_rng;
	logic                     fail;
	logic                     ins1;
	logic                     ins2;
	logic                     full;
	logic                     idx_end;

	// Bound storage and working list
	rioc_bound_mem #(
		.MAX_REGISTERS(MAX_REGISTERS),
		.MAX_BOUNDS(MAX_BOUNDS)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.reg_sel(r_q[SEL_W-1:0]),
		.rd_idx(idx_q),
		.rd_data(mem_rd),
		.wr_en(mem_wr_en),
		.wr_idx(idx_q),
		.wr_data(lst_rd),
		.cnt_rd_data(cnt_rd),
		.cnt_wr_en(cnt_wr_en),
		.cnt_wr_data(n_q)
	);

	rioc_work_list #(
		.MAX_BOUNDS(MAX_BOUNDS)
	) u_list (
		.clk(clk),
		.cmd(lcmd),
		.pos(lpos),
		.rd_idx(idx_q),
		.rd_data(lst_rd)
	);

	// Handshake and input range
	assign query.ready  = (st_q == S_IDLE);
	assign in_xfer      = query.valid && query.ready;
	assign in_rng.lo    = query.range_lower[TB-1:0];
	assign in_rng.hi    = query.range_upper[TB-1:0];
	assign in_keep      = (in_rng.hi > in_rng.lo) && (pend_cnt_q < QCNT_W'(MAX_QUERY_RANGES));

	assign result.valid      = out_valid_q;
	assign result.result_reg = out_res_q;
	assign result.is_free    = out_free_q;
	assign result.status     = out_stat_q;

	// Scan and edit decisions
	assign scan_e   = alloc_q ? lst_rd : mem_rd;
	assign qn       = (op_q == rioc_pkg::OP_STACK) ? QCNT_W'(1) : pend_cnt_q;
	assign last_rng = (q_q + QCNT_W'(1)) == qn;
	assign fail     = cur_q.occ || (!nend_q && (nxt_q < hi_q));
	assign ins1     = cur_q.tm != lo_q;
	assign ins2     = nend_q || (nxt_q > hi_q);
	assign full     = n_q >= BCNT_W'(MAX_BOUNDS);
	assign idx_end  = (BCNT_W'(idx_q) + BCNT_W'(1)) == n_q;

	assign mem_wr_en = (st_q == S_WB_WR);
	assign cnt_wr_en = (st_q == S_WB_CNT);

	// Drive working list edits
	always_comb begin
		lcmd.op   = rioc_pkg::LOP_NONE;
		lcmd.data = '0;
		lpos      = idx_q;
		case (st_q)
			S_CNT_EV: begin
				if (alloc_q && cnt_rd == '0) begin
					lcmd.op = rioc_pkg::LOP_LOAD;
					lpos    = '0;
				end
			end
			S_LD_WR: begin
				lcmd.op   = rioc_pkg::LOP_LOAD;
				lcmd.data = mem_rd;
			end
			S_EVAL: begin
				if (alloc_q && !fail) begin
					if (ins1) begin
						if (!full) begin
							lcmd.op   = rioc_pkg::LOP_INS;
							lcmd.data = '{tm: lo_q, occ: 1'b1};
							lpos      = j_q + BIDX_W'(1);
						end
					end else begin
						lcmd.op = rioc_pkg::LOP_SET;
						lpos    = j_q;
					end
				end
			end
			S_ALB: begin
				lpos = k_q + BIDX_W'(1);
				if (ins2) begin
					if (!full) begin
						lcmd.op   = rioc_pkg::LOP_INS;
						lcmd.data = '{tm: hi_q, occ: 1'b0};
					end
				end else begin
					lcmd.op = rioc_pkg::LOP_DEL;
				end
			end
			default: ;
		endcase
	end

	// Pending range store
	always_ff @(posedge clk) begin
		if (in_xfer && in_keep) begin
			pend_q[pend_cnt_q[QIDX_W-1:0]] <= in_rng;
		end
	end

	// Query sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			op_q        <= rioc_pkg::OP_CHECK;
			alloc_q     <= 1'b0;
			in_use_q    <= '0;
			pend_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Drop the answer once it transfers, unless a new one replaces it
			if (out_valid_q && result.ready && st_q != S_FIN) out_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (in_keep) pend_cnt_q <= pend_cnt_q + QCNT_W'(1);
						if (query.last_range) begin
							op_q     <= rioc_pkg::op_t'(query.operation);
							alloc_q  <= (rioc_pkg::op_t'(query.operation) == rioc_pkg::OP_ALLOC);
							st_rng_q.lo <= in_rng.lo;
							st_rng_q.hi <= (in_rng.lo == '1) ? in_rng.lo : in_rng.lo + TB'(1);
							case (rioc_pkg::op_t'(query.operation))
								rioc_pkg::OP_CHECK: begin
									r_q    <= {1'b0, query.reg_number};
									res_q  <= {1'b0, query.reg_number};
									free_q <= 1'b1;
									stat_q <= rioc_pkg::STAT_OK;
									st_q   <= ({1'b0, query.reg_number} >= in_use_q) ?
										S_FIN : S_CNT_RD;
								end
								rioc_pkg::OP_FIND: begin
									r_q    <= '0;
									res_q  <= '0;
									free_q <= 1'b1;
									stat_q <= rioc_pkg::STAT_OK;
									st_q   <= (in_use_q == '0) ? S_FIN : S_CNT_RD;
								end
								rioc_pkg::OP_ALLOC: begin
									r_q   <= {1'b0, query.reg_number};
									res_q <= {1'b0, query.reg_number};
									if ({1'b0, query.reg_number} >= RW'(MAX_REGISTERS)) begin
										free_q <= 1'b0;
										stat_q <= rioc_pkg::STAT_FULL;
										st_q   <= S_FIN;
									end else begin
										free_q <= 1'b1;
										stat_q <= rioc_pkg::STAT_OK;
										st_q   <= S_CNT_RD;
									end
								end
								default: begin
									r_q    <= in_use_q - RW'(1);
									res_q  <= '0;
									free_q <= 1'b1;
									stat_q <= rioc_pkg::STAT_OK;
									st_q   <= (in_use_q == '0) ? S_FIN : S_CNT_RD;
								end
							endcase
						end
					end
				end
				S_CNT_RD: st_q <= S_CNT_EV;
				S_CNT_EV: begin
					q_q   <= '0;
					idx_q <= '0;
					if (alloc_q) begin
						if (cnt_rd == '0) begin
							n_q  <= BCNT_W'(1);
							st_q <= (pend_cnt_q == '0) ? S_WB_RD : S_RNG;
						end else begin
							n_q  <= cnt_rd;
							st_q <= S_LD_RD;
						end
					end else if (cnt_rd == '0 || qn == '0) begin
						tfree_q <= 1'b1;
						st_q    <= S_TDONE;
					end else begin
						n_q  <= cnt_rd;
						st_q <= S_RNG;
					end
				end
				S_LD_RD: st_q <= S_LD_WR;
				S_LD_WR: begin
					if (idx_end) begin
						idx_q <= '0;
						st_q  <= (pend_cnt_q == '0) ? S_WB_RD : S_RNG;
					end else begin
						idx_q <= idx_q + BIDX_W'(1);
						st_q  <= S_LD_RD;
					end
				end
				S_RNG: begin
					idx_q <= '0;
					if (op_q == rioc_pkg::OP_STACK) begin
						lo_q <= st_rng_q.lo;
						hi_q <= st_rng_q.hi;
					end else begin
						lo_q <= pend_q[q_q[QIDX_W-1:0]].lo;
						hi_q <= pend_q[q_q[QIDX_W-1:0]].hi;
					end
					st_q <= S_SC_RD;
				end
				S_SC_RD: st_q <= S_SC_EV;
				// Walk bounds until one starts past the range start or the list ends
				S_SC_EV: begin
					if (scan_e.tm <= lo_q) begin
						cur_q <= scan_e;
						j_q   <= idx_q;
						if (idx_end) begin
							nend_q <= 1'b1;
							st_q   <= S_EVAL;
						end else begin
							idx_q <= idx_q + BIDX_W'(1);
							st_q  <= S_SC_RD;
						end
					end else begin
						nxt_q  <= scan_e.tm;
						nend_q <= 1'b0;
						st_q   <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (!alloc_q) begin
						if (fail) begin
							tfree_q <= 1'b0;
							st_q    <= S_TDONE;
						end else if (last_rng) begin
							tfree_q <= 1'b1;
							st_q    <= S_TDONE;
						end else begin
							q_q  <= q_q + QCNT_W'(1);
							st_q <= S_RNG;
						end
					end else if (fail) begin
						free_q <= 1'b0;
						stat_q <= rioc_pkg::STAT_CONFLICT;
						st_q   <= S_FIN;
					end else if (ins1) begin
						if (full) begin
							free_q <= 1'b0;
							stat_q <= rioc_pkg::STAT_FULL;
							st_q   <= S_FIN;
						end else begin
							n_q  <= n_q + BCNT_W'(1);
							k_q  <= j_q + BIDX_W'(1);
							st_q <= S_ALB;
						end
					end else begin
						k_q  <= j_q;
						st_q <= S_ALB;
					end
				end
				// Close the occupied span: split off the tail or merge with the next
				S_ALB: begin
					if (ins2 && full) begin
						free_q <= 1'b0;
						stat_q <= rioc_pkg::STAT_FULL;
						st_q   <= S_FIN;
					end else begin
						n_q <= ins2 ? n_q + BCNT_W'(1) : n_q - BCNT_W'(1);
						if (last_rng) begin
							idx_q <= '0;
							st_q  <= S_WB_RD;
						end else begin
							q_q  <= q_q + QCNT_W'(1);
							st_q <= S_RNG;
						end
					end
				end
				S_TDONE: begin
					case (op_q)
						rioc_pkg::OP_CHECK: begin
							free_q <= tfree_q;
							st_q   <= S_FIN;
						end
						rioc_pkg::OP_FIND: begin
							if (tfree_q) begin
								res_q <= r_q;
								st_q  <= S_FIN;
							end else if (r_q + RW'(1) == in_use_q) begin
								res_q <= in_use_q;
								st_q  <= S_FIN;
							end else begin
								r_q  <= r_q + RW'(1);
								st_q <= S_CNT_RD;
							end
						end
						rioc_pkg::OP_STACK: begin
							if (!tfree_q) begin
								res_q <= r_q + RW'(1);
								st_q  <= S_FIN;
							end else if (r_q == '0) begin
								res_q <= '0;
								st_q  <= S_FIN;
							end else begin
								r_q  <= r_q - RW'(1);
								st_q <= S_CNT_RD;
							end
						end
						default: st_q <= S_FIN;
					endcase
				end
				S_WB_RD: st_q <= S_WB_WR;
				S_WB_WR: begin
					if (idx_end) begin
						st_q <= S_WB_CNT;
					end else begin
						idx_q <= idx_q + BIDX_W'(1);
						st_q  <= S_WB_RD;
					end
				end
				S_WB_CNT: begin
					if (in_use_q < r_q + RW'(1)) in_use_q <= r_q + RW'(1);
					st_q <= S_FIN;
				end
				// Hand the answer to the output register
				S_FIN: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_res_q   <= res_q;
						out_free_q  <= free_q;
						out_stat_q  <= stat_q;
						pend_cnt_q  <= '0;
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q <= QCNT_W'(MAX_QUERY_RANGES))
		else $error("pending range count past its limit");
	a_in_use_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_use_q <= RW'(MAX_REGISTERS))
		else $error("registers in use past table size");
	a_list_len: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SC_EV || st_q == S_WB_WR) |-> (n_q != '0 && n_q <= BCNT_W'(MAX_BOUNDS)))
		else $error("bound list length out of range during scan");
	a_fail_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stat_q != rioc_pkg::STAT_OK) |-> !out_free_q)
		else $error("failed allocate reported as free");
`endif
endmodule
`default_nettype wire
